// ===== rtl/core/drmk_pkg.sv =====
// Shared widths, diode curve constants and types of the ring modulator kernel.
package drmk_pkg;

	// Sample format: signed, three integer bits over the fraction
	localparam int SAMPLE_BITS = 24;
	localparam int FRAC_BITS   = SAMPLE_BITS - 4;

	// Analog path: A and B held doubled, one extra fraction bit
	localparam int WIDE_FRAC = FRAC_BITS + 1;
	localparam int VW        = SAMPLE_BITS + 2;
	localparam int DIODE_W   = VW - 1;
	localparam int D_W       = WIDE_FRAC - 1;
	localparam int X_W       = WIDE_FRAC - 1;
	localparam int RECIP_W   = X_W + 1;

	localparam longint ONE_WIDE = longint'(1) << WIDE_FRAC;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [VW-1:0]          wide_t;
	typedef logic [DIODE_W-1:0]            diode_t;

	// Diode knee 0.2, linear start 0.5, linear offset 0.35
	localparam wide_t KNEE      = wide_t'((ONE_WIDE + 2) / 5);
	localparam wide_t LIN_START = wide_t'(ONE_WIDE / 2);
	localparam wide_t LIN_OFS   = wide_t'((7 * ONE_WIDE + 10) / 20);

	// Half of the quadratic divisor 3 * 2^WIDE_FRAC
	localparam longint QUAD_HALF = 3 * (ONE_WIDE / 2);

	// Reciprocal of 3, exact floor for dividends below 2^(X_W+1)
	localparam logic [RECIP_W-1:0] RECIP3 =
		RECIP_W'(((longint'(1) << (X_W + 2)) + 2) / 3);

	typedef enum logic [1:0] {
		REGION_OFF  = 2'd0,
		REGION_QUAD = 2'd1,
		REGION_LIN  = 2'd2
	} region_t;

	// Per-stage load enables handed to the diode lanes
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} adv_t;

endpackage

// ===== rtl/core/drmk_diode_lane.sv =====
// One diode curve lane: region select, square, scale and divide by three over four stages.
module drmk_diode_lane (
	input  logic             clk,
	input  drmk_pkg::adv_t   adv,
	input  drmk_pkg::wide_t  v,
	output drmk_pkg::diode_t dval
);
	import drmk_pkg::*;

	localparam int SQ_W   = 2 * D_W;
	localparam int SUM5_W = SQ_W + 3;
	localparam int MUL_W  = 2 * X_W + 2;

	region_t          region;
	wide_t            diff_knee;
	wide_t            diff_lin;
	logic [SUM5_W-1:0] sum5;
	logic [MUL_W-1:0]  mul;

	region_t          region_s2, region_s3, region_s4, region_s5;
	diode_t           lin_s2, lin_s3, lin_s4, lin_s5;
	logic [D_W-1:0]   d_s2;
	logic [SQ_W-1:0]  sq_s3;
	logic [X_W-1:0]   x_s4;
	logic [X_W-1:0]   q_s5;

	// Classify the input against knee and linear start
	assign diff_knee = v - KNEE;
	assign diff_lin  = v - LIN_OFS;

	always_comb begin
		if (v < KNEE) begin
			region = REGION_OFF;
		end else if (v < LIN_START) begin
			region = REGION_QUAD;
		end else begin
			region = REGION_LIN;
		end
	end

	// Scale the square by five and round before the divide by three
	assign sum5 = SUM5_W'({sq_s3, 2'b00}) + SUM5_W'(sq_s3) + SUM5_W'(QUAD_HALF);
	assign mul  = MUL_W'(x_s4) * MUL_W'(RECIP3);

	// Advance each stage on its load enable
	always_ff @(posedge clk) begin
		if (adv.s2) begin
			region_s2 <= region;
			lin_s2    <= diff_lin[DIODE_W-1:0];
			d_s2      <= diff_knee[D_W-1:0];
		end
		if (adv.s3) begin
			region_s3 <= region_s2;
			lin_s3    <= lin_s2;
			sq_s3     <= SQ_W'(d_s2) * SQ_W'(d_s2);
		end
		if (adv.s4) begin
			region_s4 <= region_s3;
			lin_s4    <= lin_s3;
			x_s4      <= sum5[WIDE_FRAC +: X_W];
		end
		if (adv.s5) begin
			region_s5 <= region_s4;
			lin_s5    <= lin_s4;
			q_s5      <= mul[X_W + 2 +: X_W];
		end
	end

	// Pick the curve segment
	always_comb begin
		case (region_s5)
			REGION_OFF:  dval = '0;
			REGION_QUAD: dval = DIODE_W'(q_s5);
			REGION_LIN:  dval = lin_s5;
			default:     dval = '0;
		endcase
	end

endmodule

// ===== rtl/core/diode_ring_modulator_kernel.sv =====
// Ring modulator kernel top level: handshake, seven-stage datapath and mode register.
//
// Takes one signal sample and one carrier sample per transfer and returns one
// modulated sample, all signed Q3.20. Mode 0 multiplies the samples; mode 1 runs
// the diode ring model over A = vin/2 + vc and B = vc - vin/2. One sample enters
// every clock while sample_stall is low; a result is offered once it has passed
// through the seven pipeline stages, the first of which the transfer itself loads,
// and whose longest leg is the diode lanes' square, scale and divide-by-three
// multiplier stages. Each stage holds under stall and empty stages fill in, so a
// waiting result does not block new transfers until all seven stages are full.
// Write the mode only while no sample is in flight.
module diode_ring_modulator_kernel (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  drmk_pkg::sample_t signal_sample,
	input  drmk_pkg::sample_t carrier_sample,
	output logic              result_valid,
	input  logic              result_stall,
	output drmk_pkg::sample_t modulated_sample,
	input  logic              mode_we,
	input  logic              mode_wdata
);
	import drmk_pkg::*;

	localparam int PROD_W = 2 * SAMPLE_BITS;
	localparam int RND_W  = PROD_W + 1;
	localparam int DIG_W  = RND_W - FRAC_BITS;
	localparam int SUM_W  = DIODE_W + 2;

	localparam logic signed [RND_W-1:0] PROD_HALF = RND_W'(longint'(1) << (FRAC_BITS - 1));
	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	function automatic sample_t sat(input logic signed [DIG_W-1:0] x);
		sample_t r;
		if (x > DIG_W'(SAMPLE_MAX)) begin
			r = SAMPLE_MAX;
		end else if (x < DIG_W'(SAMPLE_MIN)) begin
			r = SAMPLE_MIN;
		end else begin
			r = x[SAMPLE_BITS-1:0];
		end
		return r;
	endfunction

	logic mode_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;
	logic ld1, ld2, ld3, ld4, ld5, ld6, ld7;

	logic signed [PROD_W-1:0] prod;
	wide_t                    a2, b2;
	logic signed [DIG_W-1:0]  dig_rnd;
	logic signed [SUM_W-1:0]  sum_rnd;

	logic signed [PROD_W-1:0] p_s1;
	wide_t                    a2_s1, b2_s1;
	logic signed [DIG_W-1:0]  dig_s2;
	sample_t                  dig_s3, dig_s4, dig_s5, dig_s6;
	logic signed [SUM_W-1:0]  sum_s6;
	sample_t                  res_s7;

	adv_t   adv;
	wide_t  lane_in [4];
	diode_t dv      [4];

	// Hold the mode between writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (mode_we) begin
			mode_q <= mode_wdata;
		end
	end

	// Stall chain: a stage takes new data when empty or when the next one moves
	assign rdy7 = !valid_s7 || !result_stall;
	assign rdy6 = !valid_s6 || rdy7;
	assign rdy5 = !valid_s5 || rdy6;
	assign rdy4 = !valid_s4 || rdy5;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;

	assign ld1 = sample_valid && rdy1;
	assign ld2 = valid_s1 && rdy2;
	assign ld3 = valid_s2 && rdy3;
	assign ld4 = valid_s3 && rdy4;
	assign ld5 = valid_s4 && rdy5;
	assign ld6 = valid_s5 && rdy6;
	assign ld7 = valid_s6 && rdy7;

	assign sample_stall = !rdy1;

	// Advance valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= sample_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
			if (rdy5) valid_s5 <= valid_s4;
			if (rdy6) valid_s6 <= valid_s5;
			if (rdy7) valid_s7 <= valid_s6;
		end
	end

	// Form the product and the doubled diode drive voltages
	assign prod = PROD_W'(signal_sample) * PROD_W'(carrier_sample);
	assign a2   = VW'(signal_sample) + (VW'(carrier_sample) <<< 1);
	assign b2   = (VW'(carrier_sample) <<< 1) - VW'(signal_sample);

	// Round the product to nearest, ties up
	assign dig_rnd = DIG_W'((RND_W'(p_s1) + PROD_HALF) >>> FRAC_BITS);

	// Drop the extra fraction bit of the diode sum, ties up
	assign sum_rnd = (sum_s6 + SUM_W'(1)) >>> 1;

	// Diode lanes for A, -A, B and -B
	assign adv = '{s2: ld2, s3: ld3, s4: ld4, s5: ld5};

	assign lane_in[0] = a2_s1;
	assign lane_in[1] = -a2_s1;
	assign lane_in[2] = b2_s1;
	assign lane_in[3] = -b2_s1;

	for (genvar i = 0; i < 4; i++) begin : g_lane
		drmk_diode_lane u_lane (
			.clk  (clk),
			.adv  (adv),
			.v    (lane_in[i]),
			.dval (dv[i])
		);
	end

	// Pipeline payload registers
	always_ff @(posedge clk) begin
		if (ld1) begin
			p_s1  <= prod;
			a2_s1 <= a2;
			b2_s1 <= b2;
		end
		if (ld2) dig_s2 <= dig_rnd;
		if (ld3) dig_s3 <= sat(dig_s2);
		if (ld4) dig_s4 <= dig_s3;
		if (ld5) dig_s5 <= dig_s4;
		if (ld6) begin
			dig_s6 <= dig_s5;
			sum_s6 <= SUM_W'(dv[0]) + SUM_W'(dv[1]) - SUM_W'(dv[2]) - SUM_W'(dv[3]);
		end
		if (ld7) res_s7 <= mode_q ? sat(DIG_W'(sum_rnd)) : dig_s6;
	end

	assign result_valid     = valid_s7;
	assign modulated_sample = res_s7;

	// A stalled input means every stage is full and the output is held
	assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 &&
			valid_s5 && valid_s6 && valid_s7 && result_stall))
		else $error("input stalled with a free pipeline stage");

	// A new result only comes from the stage before
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s7) |-> $past(valid_s6))
		else $error("result valid without a source item");

	// A blocked middle stage keeps its item
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && !rdy4) |=> (valid_s4 && $stable(dig_s4)))
		else $error("blocked stage lost or changed its item");

	// Digital mode hands the saturated product straight to the output
	assert property (@(posedge clk) disable iff (!arst_n)
		(ld7 && !mode_q && !mode_we) |=> (modulated_sample == $past(dig_s6)))
		else $error("digital result not taken from the product path");

endmodule
